@@ rtl/vwtb_pkg.sv @@
`default_nettype none

package vwtb_pkg;

   // Cells are searched in groups of this many, one group per scan step
   localparam int GROUP_SIZE = 16;
   localparam int LOCAL_W    = 4;

   // Fixed field widths of the response and tolerance register
   localparam int TOL_W      = 20;
   localparam int VIDX_W     = 8;
   localparam int SCNT_W     = 9;

   // First hit within one group of cells
   typedef struct packed {
      logic               hit_any;
      logic [LOCAL_W-1:0] slot;
   } group_rec_type;

   // Control for the chain of group records
   typedef struct packed {
      logic load;
      logic shift;
   } chain_ctrl_type;

endpackage

`default_nettype wire

@@ rtl/vwtb_cell.sv @@
`default_nettype none

module vwtb_cell #(
   parameter int COORD_WIDTH = 32
) (
   input  wire logic                          clock,
   input  wire logic                          wr_en,
   input  wire logic                          live,
   input  wire logic [vwtb_pkg::TOL_W-1:0]    tol,
   input  wire logic signed [COORD_WIDTH-1:0] qx,
   input  wire logic signed [COORD_WIDTH-1:0] qy,
   input  wire logic signed [COORD_WIDTH-1:0] qz,
   output logic                               hit
);
   import vwtb_pkg::*;

   localparam int DW = (COORD_WIDTH + 1 > TOL_W + 1) ? COORD_WIDTH + 1 : TOL_W + 1;

   logic signed [COORD_WIDTH-1:0] x_ff, y_ff, z_ff;
   logic signed [DW-1:0]          dx, dy, dz, tol_pos, tol_neg;
   logic                          match;
   logic                          hit_ff;

   // Take exact per-axis differences at one extra bit
   assign dx = {{(DW-COORD_WIDTH){qx[COORD_WIDTH-1]}}, qx}
             - {{(DW-COORD_WIDTH){x_ff[COORD_WIDTH-1]}}, x_ff};
   assign dy = {{(DW-COORD_WIDTH){qy[COORD_WIDTH-1]}}, qy}
             - {{(DW-COORD_WIDTH){y_ff[COORD_WIDTH-1]}}, y_ff};
   assign dz = {{(DW-COORD_WIDTH){qz[COORD_WIDTH-1]}}, qz}
             - {{(DW-COORD_WIDTH){z_ff[COORD_WIDTH-1]}}, z_ff};

   assign tol_pos = {{(DW-TOL_W){1'b0}}, tol};
   assign tol_neg = -tol_pos;

   // Match when every axis lies within plus or minus tolerance
   assign match = (dx <= tol_pos) && (dx >= tol_neg)
               && (dy <= tol_pos) && (dy >= tol_neg)
               && (dz <= tol_pos) && (dz >= tol_neg);

   // Hold the stored vertex; capture the query on append
   always_ff @(posedge clock) begin
      if (wr_en) begin
         x_ff <= qx;
         y_ff <= qy;
         z_ff <= qz;
      end
      hit_ff <= live && match;
   end

   assign hit = hit_ff;

endmodule

`default_nettype wire

@@ rtl/vwtb_group.sv @@
`default_nettype none

module vwtb_group (
   input  wire logic                                clock,
   input  wire logic [vwtb_pkg::GROUP_SIZE-1:0]     hit,
   input  wire vwtb_pkg::chain_ctrl_type            ctrl,
   input  wire vwtb_pkg::group_rec_type             next_rec,
   output vwtb_pkg::group_rec_type                  rec
);
   import vwtb_pkg::*;

   group_rec_type own;
   group_rec_type rec_ff, rec_in;

   // Find the lowest hitting cell in the group
   always_comb begin
      own.hit_any = |hit;
      own.slot    = '0;
      for (int k = GROUP_SIZE - 1; k >= 0; k--) begin
         if (hit[k]) begin
            own.slot = LOCAL_W'(k);
         end
      end
   end

   // Load own result, or advance the neighbor's record toward the head
   always_comb begin
      rec_in = rec_ff;
      if (ctrl.load) begin
         rec_in = own;
      end else if (ctrl.shift) begin
         rec_in = next_rec;
      end
   end

   always_ff @(posedge clock) begin
      rec_ff <= rec_in;
   end

   assign rec = rec_ff;

endmodule

`default_nettype wire

@@ rtl/vertex_weld_table_with_bbox_unit.sv @@
`default_nettype none

// Flow: a request is captured in IDLE; all cells compare in CMP, each 16-entry
//   group resolves its lowest hit in GRP, then SCAN steps one group per scan
//   cycle until a hit or the end of the stored entries, and OUT responds.
// Requests: one at a time, the next taken the cycle after the response
//   handshake.
// Reset: synchronous; clears control, count and box, tolerance to 1; entries are not.
module vertex_weld_table_with_bbox_unit #(
   parameter int TABLE_DEPTH = 256,
   parameter int COORD_WIDTH = 32
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [vwtb_pkg::TOL_W-1:0]        csr_match_tolerance,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic                              req_start_new_mesh,
   input  wire logic signed [COORD_WIDTH-1:0]     req_x_coord,
   input  wire logic signed [COORD_WIDTH-1:0]     req_y_coord,
   input  wire logic signed [COORD_WIDTH-1:0]     req_z_coord,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic [vwtb_pkg::VIDX_W-1:0]            rsp_vertex_index,
   output logic                                   rsp_is_new,
   output logic                                   rsp_table_full,
   output logic [vwtb_pkg::SCNT_W-1:0]            rsp_stored_count,
   output logic signed [COORD_WIDTH-1:0]          rsp_min_x,
   output logic signed [COORD_WIDTH-1:0]          rsp_min_y,
   output logic signed [COORD_WIDTH-1:0]          rsp_min_z,
   output logic signed [COORD_WIDTH-1:0]          rsp_max_x,
   output logic signed [COORD_WIDTH-1:0]          rsp_max_y,
   output logic signed [COORD_WIDTH-1:0]          rsp_max_z
);
   import vwtb_pkg::*;

   localparam int NGROUPS = (TABLE_DEPTH + GROUP_SIZE - 1) / GROUP_SIZE;
   localparam int NCELLS  = NGROUPS * GROUP_SIZE;
   localparam int IW      = $clog2(TABLE_DEPTH);
   localparam int CW      = $clog2(TABLE_DEPTH + 1);
   localparam int BW      = $clog2(NCELLS + 1);

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_CMP  = 5'b00010,
      S_GRP  = 5'b00100,
      S_SCAN = 5'b01000,
      S_OUT  = 5'b10000
   } state_type;

   state_type                     state_ff, state_in;
   logic [TOL_W-1:0]              tol_ff, tol_in;
   logic signed [COORD_WIDTH-1:0] qx_ff, qx_in, qy_ff, qy_in, qz_ff, qz_in;
   logic [CW-1:0]                 count_ff, count_in;
   logic signed [COORD_WIDTH-1:0] lox_ff, lox_in, loy_ff, loy_in, loz_ff, loz_in;
   logic signed [COORD_WIDTH-1:0] hix_ff, hix_in, hiy_ff, hiy_in, hiz_ff, hiz_in;
   logic [BW-1:0]                 base_ff, base_in;
   logic [IW-1:0]                 idx_ff, idx_in;
   logic                          is_new_ff, is_new_in;
   logic                          full_ff, full_in;

   logic [NCELLS-1:0]             hit_vec;
   group_rec_type                 rec [NGROUPS];
   group_rec_type                 nxt [NGROUPS];
   chain_ctrl_type                chain_ctrl;
   group_rec_type                 head;
   logic                          scan_miss;
   logic                          room;
   logic                          append;
   logic [31:0]                   hit_sum;
   logic [31:0]                   idx_wide;
   logic [31:0]                   count_wide;

   // Row of storage cells, one per table entry
   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      vwtb_cell #(
         .COORD_WIDTH (COORD_WIDTH)
      ) u_cell (
         .clock (clock),
         .wr_en (append && (32'(i) == 32'(count_ff))),
         .live  (32'(i) < 32'(count_ff)),
         .tol   (tol_ff),
         .qx    (qx_ff),
         .qy    (qy_ff),
         .qz    (qz_ff),
         .hit   (hit_vec[i])
      );
   end

   // Tie off unused slots of the last group
   for (genvar i = TABLE_DEPTH; i < NCELLS; i++) begin : g_pad
      assign hit_vec[i] = 1'b0;
   end

   // Chain of group records, shifting toward group 0 during the scan
   for (genvar g = 0; g < NGROUPS; g++) begin : g_group
      if (g == NGROUPS - 1) begin : g_tail
         assign nxt[g] = '0;
      end else begin : g_link
         assign nxt[g] = rec[g+1];
      end
      vwtb_group u_group (
         .clock    (clock),
         .hit      (hit_vec[g*GROUP_SIZE +: GROUP_SIZE]),
         .ctrl     (chain_ctrl),
         .next_rec (nxt[g]),
         .rec      (rec[g])
      );
   end

   assign head      = rec[0];
   assign scan_miss = 32'(base_ff) >= 32'(count_ff);
   assign room      = 32'(count_ff) < TABLE_DEPTH;
   assign append    = (state_ff == S_SCAN) && scan_miss && room;
   assign hit_sum   = 32'(base_ff) + 32'(head.slot);

   assign chain_ctrl.load  = (state_ff == S_GRP);
   assign chain_ctrl.shift = (state_ff == S_SCAN) && !scan_miss && !head.hit_any;

   // Sequence one request: compare, resolve groups, scan, respond
   always_comb begin
      state_in  = state_ff;
      tol_in    = tol_ff;
      qx_in     = qx_ff;
      qy_in     = qy_ff;
      qz_in     = qz_ff;
      count_in  = count_ff;
      lox_in    = lox_ff;
      loy_in    = loy_ff;
      loz_in    = loz_ff;
      hix_in    = hix_ff;
      hiy_in    = hiy_ff;
      hiz_in    = hiz_ff;
      base_in   = base_ff;
      idx_in    = idx_ff;
      is_new_in = is_new_ff;
      full_in   = full_ff;

      if (csr_valid) begin
         tol_in = csr_match_tolerance;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               qx_in = req_x_coord;
               qy_in = req_y_coord;
               qz_in = req_z_coord;
               if (req_start_new_mesh) begin
                  count_in = '0;
                  lox_in   = '0;
                  loy_in   = '0;
                  loz_in   = '0;
                  hix_in   = '0;
                  hiy_in   = '0;
                  hiz_in   = '0;
               end
               state_in = S_CMP;
            end
         end
         S_CMP: begin
            state_in = S_GRP;
         end
         S_GRP: begin
            base_in  = '0;
            state_in = S_SCAN;
         end
         S_SCAN: begin
            if (scan_miss) begin
               if (room) begin
                  // Append and widen the box; the first entry seeds it
                  idx_in    = count_ff[IW-1:0];
                  is_new_in = 1'b1;
                  full_in   = 1'b0;
                  count_in  = count_ff + CW'(1);
                  if (count_ff == '0 || qx_ff < lox_ff) lox_in = qx_ff;
                  if (count_ff == '0 || qy_ff < loy_ff) loy_in = qy_ff;
                  if (count_ff == '0 || qz_ff < loz_ff) loz_in = qz_ff;
                  if (count_ff == '0 || qx_ff > hix_ff) hix_in = qx_ff;
                  if (count_ff == '0 || qy_ff > hiy_ff) hiy_in = qy_ff;
                  if (count_ff == '0 || qz_ff > hiz_ff) hiz_in = qz_ff;
               end else begin
                  // Drop the vertex
                  idx_in    = '0;
                  is_new_in = 1'b0;
                  full_in   = 1'b1;
               end
               state_in = S_OUT;
            end else if (head.hit_any) begin
               idx_in    = hit_sum[IW-1:0];
               is_new_in = 1'b0;
               full_in   = 1'b0;
               state_in  = S_OUT;
            end else begin
               base_in = base_ff + BW'(GROUP_SIZE);
            end
         end
         S_OUT: begin
            if (rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         tol_ff   <= TOL_W'(1);
         count_ff <= '0;
         lox_ff   <= '0;
         loy_ff   <= '0;
         loz_ff   <= '0;
         hix_ff   <= '0;
         hiy_ff   <= '0;
         hiz_ff   <= '0;
      end else begin
         state_ff <= state_in;
         tol_ff   <= tol_in;
         count_ff <= count_in;
         lox_ff   <= lox_in;
         loy_ff   <= loy_in;
         loz_ff   <= loz_in;
         hix_ff   <= hix_in;
         hiy_ff   <= hiy_in;
         hiz_ff   <= hiz_in;
      end
      qx_ff     <= qx_in;
      qy_ff     <= qy_in;
      qz_ff     <= qz_in;
      base_ff   <= base_in;
      idx_ff    <= idx_in;
      is_new_ff <= is_new_in;
      full_ff   <= full_in;
   end

   // Drive the ports
   assign idx_wide   = 32'(idx_ff);
   assign count_wide = 32'(count_ff);

   assign csr_ready        = 1'b1;
   assign req_ready        = (state_ff == S_IDLE);
   assign rsp_valid        = (state_ff == S_OUT);
   assign rsp_vertex_index = idx_wide[VIDX_W-1:0];
   assign rsp_is_new       = is_new_ff;
   assign rsp_table_full   = full_ff;
   assign rsp_stored_count = count_wide[SCNT_W-1:0];
   assign rsp_min_x        = lox_ff;
   assign rsp_min_y        = loy_ff;
   assign rsp_min_z        = loz_ff;
   assign rsp_max_x        = hix_ff;
   assign rsp_max_y        = hiy_ff;
   assign rsp_max_z        = hiz_ff;

   // Count stays within the table
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= TABLE_DEPTH)
      else $error("entry count beyond table depth");

   // An append grows the count by exactly one
   a_append_count: assert property (@(posedge clock) disable iff (reset)
      append |=> (count_ff == $past(count_ff) + CW'(1)))
      else $error("append did not advance the count");

   // A dropped vertex only happens on a full table
   a_full_drop: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_table_full) |-> (32'(count_ff) == TABLE_DEPTH))
      else $error("drop reported with free entries");

   // Never take a request while a response is pending
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("request taken with response pending");

   // Box stays ordered once seeded
   a_box_order: assert property (@(posedge clock) disable iff (reset)
      (count_ff != '0) |-> ((lox_ff <= hix_ff) && (loy_ff <= hiy_ff) && (loz_ff <= hiz_ff)))
      else $error("bounding box out of order");

endmodule

`default_nettype wire
